FILE: rtl/v3a_pkg.sv
// Shared constants, types and helper functions for the 3-D vector arithmetic unit.
`default_nettype none

package v3a_pkg;

  localparam int FRAC_BITS = 16;

  localparam int TOL_W = 17;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);

  // Square root: one result bit per stage, plus a rounding stage.
  localparam int SQRT_STAGES = 32;
  localparam int SQRT_IN_W   = 2 * SQRT_STAGES;
  localparam int SQRT_LAT    = SQRT_STAGES + 1;

  // Unit-vector divider: the quotient never exceeds 2^FRAC_BITS.
  localparam int Q_W     = FRAC_BITS + 1;
  localparam int N_W     = 32 + Q_W;
  localparam int DIV_LAT = Q_W;

  // Perpendicular datapath widths.
  localparam int VH_W = FRAC_BITS + 2;
  localparam int PP_W = VH_W + 33;
  localparam int PS_W = PP_W + 2;
  localparam int D_W  = PS_W - FRAC_BITS;
  localparam int VD_W = VH_W + D_W;

  localparam int SAT_W = 72;
  localparam logic signed [SAT_W-1:0] SAT_MAX = SAT_W'(64'sd2147483647);
  localparam logic signed [SAT_W-1:0] SAT_MIN = SAT_W'(-64'sd2147483648);

  typedef enum logic [3:0] {
    OP_ADD   = 4'd0,
    OP_SUB   = 4'd1,
    OP_CROSS = 4'd2,
    OP_DOT   = 4'd3,
    OP_MAG   = 4'd4,
    OP_NORM  = 4'd5,
    OP_DIST  = 4'd6,
    OP_EQ    = 4'd7,
    OP_PERP  = 4'd8
  } op_e;

  typedef struct packed {
    logic [3:0]             op;
    logic [2:0][31:0]       a;
    logic [2:0][31:0]       b;
    logic                   ac;
    logic                   bc;
    logic [2:0][32:0]       u;
    logic [2:0][31:0]       wabs;
    logic [2:0]             wneg;
    logic                   huge;
    logic [31:0]            m;
    logic [2:0][VH_W-1:0]   vh;
  } item_t;

  function automatic logic signed [32:0] sx33(input logic [31:0] x);
    return {x[31], x};
  endfunction

  // Returns {overflow, saturated 32-bit value}.
  function automatic logic [32:0] sat32(input logic signed [SAT_W-1:0] v);
    logic [32:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, 32'h7FFF_FFFF};
    end else if (v < SAT_MIN) begin
      r = {1'b1, 32'h8000_0000};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  // Rounds half up on the fraction point, then saturates.
  function automatic logic [32:0] rnd_sat(input logic signed [65:0] s);
    logic signed [65:0] t;
    t = (s + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return sat32(SAT_W'(t));
  endfunction

endpackage

`default_nettype wire

FILE: rtl/v3a_isqrt.sv
// Pipelined integer square root, rounded to nearest, one result bit per stage.
`default_nettype none

module v3a_isqrt (
  input  logic                          clk,
  input  logic [v3a_pkg::SQRT_IN_W-1:0] n,
  output logic [31:0]                   root
);
  import v3a_pkg::*;

  logic [33:0]          rem_r  [SQRT_STAGES];
  logic [31:0]          root_r [SQRT_STAGES];
  logic [SQRT_IN_W-1:0] n_r    [SQRT_STAGES];

  logic [33:0]          rem_next  [SQRT_STAGES];
  logic [31:0]          root_next [SQRT_STAGES];
  logic [SQRT_IN_W-1:0] n_next    [SQRT_STAGES];

  always_comb begin
    logic [33:0]          s_rem;
    logic [31:0]          s_root;
    logic [SQRT_IN_W-1:0] s_n;
    logic [35:0]          t;
    logic [35:0]          trial;
    logic                 ge;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      if (k == 0) begin
        s_rem  = '0;
        s_root = '0;
        s_n    = n;
      end else begin
        s_rem  = rem_r[k-1];
        s_root = root_r[k-1];
        s_n    = n_r[k-1];
      end
      t     = {s_rem, s_n[SQRT_IN_W-1 -: 2]};
      trial = {2'b00, s_root, 2'b01};
      ge    = (t >= trial);
      rem_next[k]  = ge ? 34'(t - trial) : t[33:0];
      root_next[k] = {s_root[30:0], ge};
      n_next[k]    = s_n << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SQRT_STAGES; k++) begin
      rem_r[k]  <= rem_next[k];
      root_r[k] <= root_next[k];
      n_r[k]    <= n_next[k];
    end
    if (rem_r[SQRT_STAGES-1] > {2'b00, root_r[SQRT_STAGES-1]}) begin
      root <= root_r[SQRT_STAGES-1] + 32'd1;
    end else begin
      root <= root_r[SQRT_STAGES-1];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/v3a_div.sv
// Pipelined restoring divider for one unit-vector lane, one quotient bit per stage.
`default_nettype none

module v3a_div (
  input  logic                    clk,
  input  logic [v3a_pkg::N_W-1:0] num,
  input  logic [31:0]             den,
  output logic [v3a_pkg::Q_W-1:0] quo
);
  import v3a_pkg::*;

  logic [31:0]    rem_r [Q_W];
  logic [31:0]    den_r [Q_W];
  logic [Q_W-1:0] low_r [Q_W];
  logic [Q_W-1:0] quo_r [Q_W];

  logic [31:0]    rem_next [Q_W];
  logic [31:0]    den_next [Q_W];
  logic [Q_W-1:0] low_next [Q_W];
  logic [Q_W-1:0] quo_next [Q_W];

  // The quotient fits in Q_W bits, so the top numerator bits start below the divisor.
  always_comb begin
    logic [31:0]    s_rem;
    logic [31:0]    s_den;
    logic [Q_W-1:0] s_low;
    logic [Q_W-1:0] s_quo;
    logic [32:0]    t;
    logic           ge;
    for (int k = 0; k < Q_W; k++) begin
      if (k == 0) begin
        s_rem = num[N_W-1:Q_W];
        s_den = den;
        s_low = num[Q_W-1:0];
        s_quo = '0;
      end else begin
        s_rem = rem_r[k-1];
        s_den = den_r[k-1];
        s_low = low_r[k-1];
        s_quo = quo_r[k-1];
      end
      t  = {s_rem, s_low[Q_W-1]};
      ge = (t >= {1'b0, s_den});
      rem_next[k] = ge ? 32'(t - {1'b0, s_den}) : t[31:0];
      den_next[k] = s_den;
      low_next[k] = s_low << 1;
      quo_next[k] = {s_quo[Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      rem_r[k] <= rem_next[k];
      den_r[k] <= den_next[k];
      low_r[k] <= low_next[k];
      quo_r[k] <= quo_next[k];
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

`default_nettype wire

FILE: rtl/vector3_arithmetic_unit.sv
// Top level of the pipelined 3-D fixed-point vector arithmetic unit.
//
//   Channel   | Handshake          | Word
//   ----------+--------------------+----------------------------------------------
//   command   | start, busy        | opcode, a_*, a_current, b_*, b_current, c_*
//   result    | done (strobe)      | res_x/y/z, res_scalar, res_equal,
//             |                    | res_current, res_overflow
//   config    | cfg_we             | cfg_wdata (equality tolerance)
//
// A command word is taken at every clock edge where start is high; busy is
// always low because the pipeline never holds. Every command produces exactly
// one result word, on the ports for one cycle with done high. Every word
// passes through the 32-stage square root and the 17-stage unit-vector
// dividers, whatever its opcode, so that results stay in order.
// Synchronous reset clears the valid bits and done and restores the tolerance
// to its reset value; no result is lost except those in flight at reset.
`default_nettype none

module vector3_arithmetic_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [3:0]                 opcode,
  input  logic signed [31:0]         a_x,
  input  logic signed [31:0]         a_y,
  input  logic signed [31:0]         a_z,
  input  logic                       a_current,
  input  logic signed [31:0]         b_x,
  input  logic signed [31:0]         b_y,
  input  logic signed [31:0]         b_z,
  input  logic                       b_current,
  input  logic signed [31:0]         c_x,
  input  logic signed [31:0]         c_y,
  input  logic signed [31:0]         c_z,
  input  logic                       cfg_we,
  input  logic [v3a_pkg::TOL_W-1:0]  cfg_wdata,
  output logic                       done,
  output logic signed [31:0]         res_x,
  output logic signed [31:0]         res_y,
  output logic signed [31:0]         res_z,
  output logic signed [31:0]         res_scalar,
  output logic                       res_equal,
  output logic                       res_current,
  output logic                       res_overflow
);
  import v3a_pkg::*;

  // Stage map: 0 input, 1 differences and operand select, 2 squares, 3 sum of
  // squares into the root, I_M root out and divider in, I_Q quotients out,
  // then four stages of projection and cross/dot arithmetic, LAST feeds the
  // output register.
  localparam int I_M    = 3 + SQRT_LAT;
  localparam int I_Q    = I_M + DIV_LAT;
  localparam int LAST   = I_Q + 4;
  localparam int PIPE_N = LAST + 1;

  logic [TOL_W-1:0]  tol;
  item_t             pipe [PIPE_N];
  logic [PIPE_N-1:0] vld;
  logic [2:0][31:0]  c0;

  item_t             item_in;
  item_t             st1;
  item_t             m_stage_next;
  item_t             vh_stage_next;
  logic signed [32:0] uu [3];
  logic signed [32:0] vv [3];
  logic signed [32:0] ww [3];
  logic [32:0]        wa [3];
  logic               vbig;
  logic               huge;

  logic [63:0]        sq_r [3];
  logic [63:0]        ssum_r;
  logic [31:0]        root_m;
  logic [N_W-1:0]     num [3];
  logic [Q_W-1:0]     quo [3];
  logic [2:0][VH_W-1:0] vh_c;

  logic signed [PP_W-1:0] pp_r [3];
  logic signed [PS_W-1:0] psum;
  logic signed [D_W-1:0]  d_r;
  logic signed [VD_W-1:0] vd_r [3];
  logic signed [63:0]     abp_r [9];
  logic [32:0]            xd_r [4];

  logic [31:0]            rv [3];
  logic [31:0]            sc;
  logic                   eq;
  logic                   cur;
  logic                   ovf;
  logic signed [SAT_W-1:0] pt [3];
  logic [32:0]            ls [3];
  logic [32:0]            ua [3];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_wdata;
    end
  end

  always_comb begin
    item_in      = '0;
    item_in.op   = opcode;
    item_in.a    = {a_z, a_y, a_x};
    item_in.b    = {b_z, b_y, b_x};
    item_in.ac   = a_current;
    item_in.bc   = b_current;
  end

  // Stage 1: u = a - b, v = c - b, and the vector whose length is needed.
  // A line direction too long for the square root is halved first.
  always_comb begin
    st1  = pipe[0];
    vbig = 1'b0;
    huge = 1'b0;
    for (int i = 0; i < 3; i++) begin
      uu[i] = sx33(pipe[0].a[i]) - sx33(pipe[0].b[i]);
      vv[i] = sx33(c0[i]) - sx33(pipe[0].b[i]);
      if (vv[i] > 33'sd2147483648 || vv[i] < -33'sd2147483648) begin
        vbig = 1'b1;
      end
      if (uu[i] >= 33'sd2147483648 || uu[i] <= -33'sd2147483648) begin
        huge = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (pipe[0].op == OP_DIST) begin
        ww[i] = uu[i];
      end else if (pipe[0].op == OP_PERP) begin
        ww[i] = vbig ? (vv[i] >>> 1) : vv[i];
      end else begin
        ww[i] = sx33(pipe[0].a[i]);
      end
      wa[i]         = ww[i][32] ? 33'(-ww[i]) : 33'(ww[i]);
      st1.u[i]      = 33'(uu[i]);
      st1.wneg[i]   = ww[i][32];
      st1.wabs[i]   = wa[i][31:0];
    end
    st1.huge = huge;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq_r[i] <= {32'b0, pipe[1].wabs[i]} * {32'b0, pipe[1].wabs[i]};
    end
    ssum_r <= sq_r[0] + sq_r[1] + sq_r[2];
  end

  v3a_isqrt u_isqrt (
    .clk  (clk),
    .n    (ssum_r),
    .root (root_m)
  );

  // Unit component magnitude is (|w_i| * 2^F + m/2) / m, rounded half away from zero.
  for (genvar g = 0; g < 3; g++) begin : g_div
    assign num[g] = N_W'({pipe[I_M].wabs[g], {FRAC_BITS{1'b0}}}) + N_W'(root_m >> 1);
    v3a_div u_div (
      .clk (clk),
      .num (num[g]),
      .den (root_m),
      .quo (quo[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pipe[I_Q].m == '0) begin
        vh_c[i] = '0;
      end else if (pipe[I_Q].wneg[i]) begin
        vh_c[i] = VH_W'(-signed'({1'b0, quo[i]}));
      end else begin
        vh_c[i] = VH_W'({1'b0, quo[i]});
      end
    end
  end

  // The root and the unit vector join the word as it moves on.
  always_comb begin
    m_stage_next     = pipe[I_M];
    m_stage_next.m   = root_m;
    vh_stage_next    = pipe[I_Q];
    vh_stage_next.vh = vh_c;
  end

  always_ff @(posedge clk) begin
    pipe[0] <= item_in;
    c0      <= {c_z, c_y, c_x};
    pipe[1] <= st1;
    for (int k = 2; k < PIPE_N; k++) begin
      if (k == I_M + 1) begin
        pipe[k] <= m_stage_next;
      end else if (k == I_Q + 1) begin
        pipe[k] <= vh_stage_next;
      end else begin
        pipe[k] <= pipe[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PIPE_N-2:0], start & ~busy};
    end
  end

  // Projection length d = round(v_hat . u), then v_hat * d.
  always_comb begin
    psum = PS_W'(pp_r[0]) + PS_W'(pp_r[1]) + PS_W'(pp_r[2])
         + (PS_W'(1) <<< (FRAC_BITS - 1));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pp_r[i] <= signed'(pipe[I_Q+1].vh[i]) * signed'(pipe[I_Q+1].u[i]);
      vd_r[i] <= signed'(pipe[I_Q+3].vh[i]) * d_r;
    end
    d_r <= D_W'(psum >>> FRAC_BITS);
  end

  // Cross and dot products: products in one stage, rounded sums in the next.
  always_ff @(posedge clk) begin
    abp_r[0] <= signed'(pipe[I_Q+2].a[1]) * signed'(pipe[I_Q+2].b[2]);
    abp_r[1] <= signed'(pipe[I_Q+2].a[2]) * signed'(pipe[I_Q+2].b[1]);
    abp_r[2] <= signed'(pipe[I_Q+2].a[2]) * signed'(pipe[I_Q+2].b[0]);
    abp_r[3] <= signed'(pipe[I_Q+2].a[0]) * signed'(pipe[I_Q+2].b[2]);
    abp_r[4] <= signed'(pipe[I_Q+2].a[0]) * signed'(pipe[I_Q+2].b[1]);
    abp_r[5] <= signed'(pipe[I_Q+2].a[1]) * signed'(pipe[I_Q+2].b[0]);
    abp_r[6] <= signed'(pipe[I_Q+2].a[0]) * signed'(pipe[I_Q+2].b[0]);
    abp_r[7] <= signed'(pipe[I_Q+2].a[1]) * signed'(pipe[I_Q+2].b[1]);
    abp_r[8] <= signed'(pipe[I_Q+2].a[2]) * signed'(pipe[I_Q+2].b[2]);
    xd_r[0]  <= rnd_sat(66'(abp_r[0]) - 66'(abp_r[1]));
    xd_r[1]  <= rnd_sat(66'(abp_r[2]) - 66'(abp_r[3]));
    xd_r[2]  <= rnd_sat(66'(abp_r[4]) - 66'(abp_r[5]));
    xd_r[3]  <= rnd_sat(66'(abp_r[6]) + 66'(abp_r[7]) + 66'(abp_r[8]));
  end

  // Final selection by opcode, with saturation into the 32-bit result fields.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rv[i] = '0;
      pt[i] = (SAT_W'(vd_r[i]) + (SAT_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      ls[i] = '0;
      ua[i] = pipe[LAST].u[i][32] ? 33'(-signed'(pipe[LAST].u[i])) : pipe[LAST].u[i];
    end
    sc  = '0;
    eq  = 1'b0;
    ovf = 1'b0;
    cur = pipe[LAST].ac & pipe[LAST].bc;
    unique case (pipe[LAST].op)
      OP_ADD: begin
        for (int i = 0; i < 3; i++) begin
          ls[i] = sat32(SAT_W'(sx33(pipe[LAST].a[i]) + sx33(pipe[LAST].b[i])));
          rv[i] = ls[i][31:0];
          ovf   = ovf | ls[i][32];
        end
      end
      OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          ls[i] = sat32(SAT_W'(signed'(pipe[LAST].u[i])));
          rv[i] = ls[i][31:0];
          ovf   = ovf | ls[i][32];
        end
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          rv[i] = xd_r[i][31:0];
          ovf   = ovf | xd_r[i][32];
        end
      end
      OP_DOT: begin
        sc  = xd_r[3][31:0];
        ovf = xd_r[3][32];
      end
      OP_MAG: begin
        cur   = pipe[LAST].ac;
        ls[0] = sat32(SAT_W'({1'b0, pipe[LAST].m}));
        sc    = ls[0][31:0];
        ovf   = ls[0][32];
      end
      OP_NORM: begin
        cur = (pipe[LAST].m == '0) | pipe[LAST].ac;
        for (int i = 0; i < 3; i++) begin
          rv[i] = 32'(signed'(pipe[LAST].vh[i]));
        end
      end
      OP_DIST: begin
        if (pipe[LAST].huge) begin
          sc  = 32'h7FFF_FFFF;
          ovf = 1'b1;
        end else begin
          ls[0] = sat32(SAT_W'({1'b0, pipe[LAST].m}));
          sc    = ls[0][31:0];
          ovf   = ls[0][32];
        end
      end
      OP_EQ: begin
        eq = (ua[0] < 33'(tol)) && (ua[1] < 33'(tol)) && (ua[2] < 33'(tol));
      end
      OP_PERP: begin
        for (int i = 0; i < 3; i++) begin
          ls[i] = sat32(SAT_W'(signed'(pipe[LAST].u[i])) - pt[i]);
          rv[i] = ls[i][31:0];
          ovf   = ovf | ls[i][32];
        end
      end
      default: begin
        cur = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[LAST];
    end
    res_x        <= rv[0];
    res_y        <= rv[1];
    res_z        <= rv[2];
    res_scalar   <= sc;
    res_equal    <= eq;
    res_current  <= cur;
    res_overflow <= ovf;
  end

  // Every accepted command comes out after the fixed pipeline latency.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(PIPE_N + 1) done)
    else $error("result word missing at the pipeline latency");

  // The rounded root is never shorter than any component it was taken over.
  assert property (@(posedge clk) disable iff (rst)
    (vld[I_M] && (pipe[I_M].op == OP_MAG || pipe[I_M].op == OP_NORM))
    |-> (root_m >= pipe[I_M].wabs[0] && root_m >= pipe[I_M].wabs[1]
         && root_m >= pipe[I_M].wabs[2]))
    else $error("square root below a component magnitude");

  // Unit-vector components never exceed one.
  assert property (@(posedge clk) disable iff (rst)
    (vld[I_Q] && (pipe[I_Q].op == OP_NORM || pipe[I_Q].op == OP_PERP)
     && pipe[I_Q].m != '0)
    |-> (quo[0] <= Q_W'(1 << FRAC_BITS) && quo[1] <= Q_W'(1 << FRAC_BITS)
         && quo[2] <= Q_W'(1 << FRAC_BITS)))
    else $error("unit vector component above one");

  // Normalize never saturates.
  assert property (@(posedge clk) disable iff (rst)
    (vld[LAST] && pipe[LAST].op == OP_NORM) |=> (done && !res_overflow))
    else $error("normalize flagged overflow");

endmodule

`default_nettype wire

FILE: tb/sv/vector3_arithmetic_unit_tb.sv
// Self-checking testbench for the 3-D fixed-point vector arithmetic unit.
`default_nettype none

module vector3_arithmetic_unit_tb;
  import v3a_pkg::*;

  // Predictor arithmetic is carried at 128 bits, so that no sum of
  // products can wrap before it is rounded and saturated.
  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [3:0]  op;
    logic [31:0] a [3];
    logic [31:0] b [3];
    logic [31:0] c [3];
    logic        ac;
    logic        bc;
  } cmd_word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] sc;
    logic        eq;
    logic        cur;
    logic        ovf;
  } res_word_t;

  localparam int  RANDOM_ITEMS = 450;
  localparam int  PHASE_ITEMS  = RANDOM_ITEMS / 5;
  localparam int  SETTLE       = 70;      // a little more than the pipeline latency
  localparam int  CYCLE_LIMIT  = 200000;
  localparam wide_t HALF_LSB   = wide_t'(1) <<< (FRAC_BITS - 1);
  localparam wide_t TWO_31     = wide_t'(1) <<< 31;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [3:0] opcode = '0;
  logic signed [31:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [31:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [31:0] c_x = '0, c_y = '0, c_z = '0;
  logic a_current = 1'b0, b_current = 1'b0;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_wdata = '0;
  logic done;
  logic signed [31:0] res_x, res_y, res_z, res_scalar;
  logic res_equal, res_current, res_overflow;

  vector3_arithmetic_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_current(a_current),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_current(b_current),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .done(done), .res_x(res_x), .res_y(res_y), .res_z(res_z),
    .res_scalar(res_scalar), .res_equal(res_equal),
    .res_current(res_current), .res_overflow(res_overflow)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cmd_word_t  cmd_pending [$];     // command words waiting to be driven
  res_word_t  res_awaited [$];     // predicted result words, oldest first
  logic [TOL_W-1:0] tolerance = TOL_RESET;  // our copy of the tolerance register
  bit  allow_idle = 1'b1;
  int  errors = 0;
  int  cycles = 0;
  int  op_seen [16];
  int  results_checked = 0;

  // ---------------------------------------------------------------------------
  // Predictor helpers.
  // ---------------------------------------------------------------------------

  // Returns {overflow, value} with the value clamped to the signed 32-bit range.
  function automatic logic [32:0] clamp32(input wide_t v);
    if (v > wide_t'(32'sh7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    if (v < -TWO_31) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  // Shift right by the fraction width, rounding half toward +infinity.
  function automatic wide_t round_frac(input wide_t v);
    return (v + HALF_LSB) >>> FRAC_BITS;
  endfunction

  function automatic wide_t mag_of(input wide_t v);
    return v < 0 ? -v : v;
  endfunction

  // Integer square root rounded to nearest.
  function automatic logic [63:0] sqrt_round(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n = n - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return n > root ? root + 1 : root;
  endfunction

  // Rounded length; each component must be at most 2^31 in magnitude.
  function automatic wide_t vec_len(input wide_t x, input wide_t y, input wide_t z);
    logic [63:0] s;
    wide_t mx, my, mz;
    mx = mag_of(x);
    my = mag_of(y);
    mz = mag_of(z);
    s = mx[63:0] * mx[63:0] + my[63:0] * my[63:0] + mz[63:0] * mz[63:0];
    return wide_t'(sqrt_round(s));
  endfunction

  // Unit vector scaled by 2^FRAC_BITS, with each division rounded half away
  // from zero. Returns 1 for the zero vector.
  function automatic bit unit_vec(input wide_t x, input wide_t y, input wide_t z,
                                  output wide_t ux, output wide_t uy, output wide_t uz);
    wide_t m;
    wide_t comp [3];
    wide_t q [3];
    m = vec_len(x, y, z);
    comp[0] = x;
    comp[1] = y;
    comp[2] = z;
    if (m == 0) begin
      ux = 0;
      uy = 0;
      uz = 0;
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      q[i] = ((mag_of(comp[i]) <<< FRAC_BITS) + (m >>> 1)) / m;
      if (comp[i] < 0) q[i] = -q[i];
    end
    ux = q[0];
    uy = q[1];
    uz = q[2];
    return 1'b0;
  endfunction

  // Works out the result word that one command word must produce.
  function automatic res_word_t predict_result(input cmd_word_t w);
    res_word_t r;
    wide_t a [3], b [3], c [3], vr [3], u [3], v [3], vh [3];
    wide_t sc, d;
    logic [32:0] cl;
    bit ovf, huge;
    for (int i = 0; i < 3; i++) begin
      a[i] = wide_t'(signed'(w.a[i]));
      b[i] = wide_t'(signed'(w.b[i]));
      c[i] = wide_t'(signed'(w.c[i]));
      vr[i] = 0;
    end
    sc = 0;
    ovf = 1'b0;
    r.eq = 1'b0;
    r.cur = w.ac & w.bc;
    case (w.op)
      OP_ADD: for (int i = 0; i < 3; i++) vr[i] = a[i] + b[i];
      OP_SUB: for (int i = 0; i < 3; i++) vr[i] = a[i] - b[i];
      OP_CROSS: begin
        vr[0] = round_frac(a[1] * b[2] - a[2] * b[1]);
        vr[1] = round_frac(a[2] * b[0] - a[0] * b[2]);
        vr[2] = round_frac(a[0] * b[1] - a[1] * b[0]);
      end
      OP_DOT: sc = round_frac(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
      OP_MAG: begin
        r.cur = w.ac;
        sc = vec_len(a[0], a[1], a[2]);
      end
      OP_NORM: begin
        // A zero vector normalizes to zero and counts as current.
        r.cur = unit_vec(a[0], a[1], a[2], vr[0], vr[1], vr[2]) ? 1'b1 : w.ac;
      end
      OP_DIST: begin
        for (int i = 0; i < 3; i++) u[i] = a[i] - b[i];
        if (mag_of(u[0]) >= TWO_31 || mag_of(u[1]) >= TWO_31 || mag_of(u[2]) >= TWO_31) begin
          sc = TWO_31;   // clamps to the maximum and flags overflow
        end else begin
          sc = vec_len(u[0], u[1], u[2]);
        end
      end
      OP_EQ: begin
        r.eq = 1'b1;
        for (int i = 0; i < 3; i++)
          if (mag_of(a[i] - b[i]) >= wide_t'(tolerance)) r.eq = 1'b0;
      end
      OP_PERP: begin
        huge = 1'b0;
        for (int i = 0; i < 3; i++) begin
          u[i] = a[i] - b[i];
          v[i] = c[i] - b[i];
          if (mag_of(v[i]) > TWO_31) huge = 1'b1;
        end
        // An oversized line direction is halved only for finding its unit vector.
        if (huge) for (int i = 0; i < 3; i++) v[i] = v[i] >>> 1;
        void'(unit_vec(v[0], v[1], v[2], vh[0], vh[1], vh[2]));
        d = round_frac(vh[0] * u[0] + vh[1] * u[1] + vh[2] * u[2]);
        for (int i = 0; i < 3; i++) vr[i] = u[i] - round_frac(vh[i] * d);
      end
      default: r.cur = 1'b0;
    endcase
    cl = clamp32(vr[0]); r.x = cl[31:0]; ovf |= cl[32];
    cl = clamp32(vr[1]); r.y = cl[31:0]; ovf |= cl[32];
    cl = clamp32(vr[2]); r.z = cl[31:0]; ovf |= cl[32];
    cl = clamp32(sc);    r.sc = cl[31:0]; ovf |= cl[32];
    r.ovf = ovf;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending command word, with random idle bursts.
  // busy should never rise, but a word is only replaced once it was taken.
  // ---------------------------------------------------------------------------
  cmd_word_t drv_word;
  int idle_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      idle_left = 0;
    end else if (!(start && busy)) begin
      if (start) begin
        res_awaited.push_back(predict_result(drv_word));
        op_seen[drv_word.op]++;
      end
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        drv_word = cmd_pending.pop_front();
        opcode <= drv_word.op;
        a_x <= drv_word.a[0]; a_y <= drv_word.a[1]; a_z <= drv_word.a[2];
        b_x <= drv_word.b[0]; b_y <= drv_word.b[1]; b_z <= drv_word.b[2];
        c_x <= drv_word.c[0]; c_y <= drv_word.c[1]; c_z <= drv_word.c[2];
        a_current <= drv_word.ac;
        b_current <= drv_word.bc;
        start <= 1'b1;
        if (allow_idle && $urandom_range(0, 5) == 0) idle_left = $urandom_range(1, 8);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every strobed result word is matched against the oldest prediction.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_word_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d results outstanding",
               $time, res_awaited.size());
      $display("vector3_arithmetic_unit_tb: errors");
      $finish;
    end else if (!rst && done) begin
      if (res_awaited.size() == 0) begin
        $display("%0t: result word with no prediction waiting", $time);
        errors++;
      end else begin
        e = res_awaited.pop_front();
        check_field("res_x", e.x, res_x);
        check_field("res_y", e.y, res_y);
        check_field("res_z", e.z, res_z);
        check_field("res_scalar", e.sc, res_scalar);
        check_field("res_equal", 32'(e.eq), 32'(res_equal));
        check_field("res_current", 32'(e.cur), 32'(res_current));
        check_field("res_overflow", 32'(e.ovf), 32'(res_overflow));
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  task automatic add_word(input logic [3:0] op,
                          input logic [31:0] ax, input logic [31:0] ay,
                          input logic [31:0] az, input logic ac,
                          input logic [31:0] bx, input logic [31:0] by,
                          input logic [31:0] bz, input logic bc,
                          input logic [31:0] cx, input logic [31:0] cy,
                          input logic [31:0] cz);
    cmd_word_t w;
    w.op = op;
    w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
    w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
    w.c[0] = cx; w.c[1] = cy; w.c[2] = cz;
    w.ac = ac;
    w.bc = bc;
    cmd_pending.push_back(w);
  endtask

  // Coordinates mix full-range noise, small values, extremes and mid values.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1 << 21) - (1 << 20);
      1: case ($urandom_range(0, 4))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0000_0000;
           3: return 32'hFFFF_FFFF;
           default: return 32'h0001_0000;
         endcase
      2: return $urandom_range(0, 1 << 25) - (1 << 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] near(input logic [31:0] base, input int span);
    return base + ($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic add_random_word();
    cmd_word_t w;
    int span;
    w.op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    for (int i = 0; i < 3; i++) begin
      w.a[i] = rand_coord();
      w.b[i] = rand_coord();
      w.c[i] = rand_coord();
    end
    // Equality is only interesting when the points lie close together, and a
    // perpendicular is easier to reason about on a short, nearby line.
    span = (tolerance == 0) ? 4 : int'(tolerance) + 2;
    if (w.op == OP_EQ && $urandom_range(0, 3) != 0)
      for (int i = 0; i < 3; i++) w.b[i] = near(w.a[i], span);
    if (w.op == OP_PERP && $urandom_range(0, 1) == 0)
      for (int i = 0; i < 3; i++) w.c[i] = near(w.b[i], 1 << 18);
    w.ac = 1'($urandom);
    w.bc = 1'($urandom);
    cmd_pending.push_back(w);
  endtask

  // Holds the sender until every predicted result has been seen.
  task automatic wait_drained();
    do @(negedge clk);
    while (cmd_pending.size() != 0 || start || res_awaited.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tolerance = v;
    @(negedge clk);
  endtask

  initial begin
    logic [TOL_W-1:0] tol_plan [5];
    localparam logic [31:0] MAXP = 32'h7FFF_FFFF;
    localparam logic [31:0] MINN = 32'h8000_0000;
    localparam logic [31:0] ONE  = 32'h0001_0000;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words, at the reset tolerance of one raw unit.
    add_word(OP_ADD,   MAXP, MAXP, 0, 1,    MAXP, 1, 0, 1,    0, 0, 0);   // positive clamp
    add_word(OP_ADD,   MINN, MINN, 5, 1,    MINN, 32'hFFFF_FFFF, 7, 0, 0, 0, 0); // negative clamp
    add_word(OP_SUB,   MINN, MAXP, 0, 0,    MAXP, MINN, 0, 1, 0, 0, 0);
    add_word(OP_CROSS, MAXP, MINN, MAXP, 1, MINN, MAXP, MINN, 1, 0, 0, 0);
    add_word(OP_CROSS, ONE, 0, 0, 1,        0, ONE, 0, 1,     0, 0, 0);
    add_word(OP_DOT,   MINN, MINN, MINN, 1, MINN, MINN, MINN, 1, 0, 0, 0);
    add_word(OP_DOT,   32'h0000_8000, 0, 0, 1, 32'h0000_0001, 0, 0, 1, 0, 0, 0); // half rounds up
    add_word(OP_MAG,   MINN, MINN, MINN, 1, 0, 0, 0, 0,       0, 0, 0);
    add_word(OP_MAG,   3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 1,    0, 0, 0);
    add_word(OP_NORM,  0, 0, 0, 0,          0, 0, 0, 0,       0, 0, 0);   // zero vector
    add_word(OP_NORM,  MINN, 0, 0, 0,       0, 0, 0, 1,       0, 0, 0);
    add_word(OP_NORM,  MAXP, MAXP, MINN, 1, 0, 0, 0, 0,       0, 0, 0);
    add_word(OP_DIST,  MAXP, 0, 0, 1,       MINN, 0, 0, 1,    0, 0, 0);   // huge separation
    add_word(OP_DIST,  32'h4000_0000, 0, 0, 1, 32'hC000_0000, 0, 0, 1, 0, 0, 0); // exactly 2^31
    add_word(OP_DIST,  ONE, ONE, ONE, 1,    0, 0, 0, 1,       0, 0, 0);
    add_word(OP_EQ,    ONE, 7, MINN, 1,     ONE, 7, MINN, 1,  0, 0, 0);   // identical
    add_word(OP_EQ,    ONE, 7, 0, 1,        ONE, 8, 0, 1,     0, 0, 0);   // one unit off
    add_word(OP_EQ,    MAXP, 0, 0, 1,       MINN, 0, 0, 1,    0, 0, 0);
    add_word(OP_PERP,  ONE, ONE, 0, 1,      0, 0, 0, 1,       0, 0, 0);   // zero direction
    add_word(OP_PERP,  MAXP, MINN, MAXP, 1, MINN, MAXP, MINN, 1, MAXP, MINN, MAXP); // huge line
    add_word(OP_PERP,  ONE, 2 * ONE, 0, 1,  0, 0, 0, 1,       4 * ONE, 0, 0);
    add_word(4'd9,     MAXP, MAXP, MAXP, 1, MAXP, MAXP, MAXP, 1, 0, 0, 0); // unknown opcode
    add_word(4'd15,    1, 1, 1, 1,          1, 1, 1, 1,       1, 1, 1);
    wait_drained();

    // Random phases across tolerance settings, including both ends of the field.
    tol_plan[0] = 17'd65536;
    tol_plan[1] = 17'd0;
    tol_plan[2] = 17'd131071;
    tol_plan[3] = TOL_RESET;
    tol_plan[4] = 17'($urandom_range(1, 65536));
    for (int p = 0; p < 5; p++) begin
      write_tolerance(tol_plan[p]);
      if (p == 4) allow_idle = 1'b0;   // the last phase runs back to back
      for (int n = 0; n < PHASE_ITEMS; n++) add_random_word();
      wait_drained();
    end

    repeat (SETTLE) @(negedge clk);
    if (res_awaited.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, res_awaited.size());
      errors++;
    end
    $display("Checked %0d result words over five tolerance settings and the reset value;",
             results_checked);
    $display("words per opcode 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d, unknown opcodes too.",
             op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
             op_seen[5], op_seen[6], op_seen[7], op_seen[8]);
    if (errors == 0) begin
      $display("vector3_arithmetic_unit_tb: clean");
    end else begin
      $display("vector3_arithmetic_unit_tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
rtl/v3a_pkg.sv
rtl/v3a_isqrt.sv
rtl/v3a_div.sv
rtl/vector3_arithmetic_unit.sv
tb/sv/vector3_arithmetic_unit_tb.sv
